FILE: src/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared constants and types for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int LPR_MAX_FRAMES = 8;
    localparam int LPR_PAGE_BITS  = 16;
    localparam int LPR_CFG_W      = 4;
    localparam int LPR_FAULT_W    = 32;

    localparam logic [LPR_CFG_W-1:0] LPR_FRAMES_RESET = 4'd8;

    typedef struct packed {
        logic hit;
        logic evicted_valid;
    } lpr_status_t;

endpackage

FILE: src/lpr_if.sv
// ----------------------------------------------------------------------------
// lpr_if
// Request, result and configuration channels of the LRU page replacement block.
// ----------------------------------------------------------------------------
interface lpr_req_if
    import lpr_pkg::*;
#(
    parameter int PAGE_BITS = LPR_PAGE_BITS
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;
    logic                 final_access;

    modport source (output valid, output page, output final_access, input ready);
    modport sink   (input valid, input page, input final_access, output ready);
endinterface

interface lpr_rsp_if
    import lpr_pkg::*;
#(
    parameter int PAGE_BITS = LPR_PAGE_BITS,
    parameter int SLOT_W    = 3
);
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [SLOT_W-1:0]      slot;
    logic                   evicted_valid;
    logic [PAGE_BITS-1:0]   evicted_page;
    logic [LPR_FAULT_W-1:0] fault_count;

    modport source (output valid, output hit, output slot, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input slot, input evicted_valid,
                    input evicted_page, input fault_count, output ready);
endinterface

interface lpr_cfg_if
    import lpr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [LPR_CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/lpr_policy.sv
// ----------------------------------------------------------------------------
// lpr_policy
// Single-pass lookup, victim choice and recency update for one reference.
// ----------------------------------------------------------------------------
module lpr_policy
    import lpr_pkg::*;
#(
    parameter int MAX_FRAMES = LPR_MAX_FRAMES,
    parameter int PAGE_BITS  = LPR_PAGE_BITS,
    parameter int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    parameter int CNT_W      = $clog2(MAX_FRAMES + 1)
)
(
    input  logic [PAGE_BITS-1:0]   page,
    input  logic                   final_access,
    input  logic [LPR_CFG_W-1:0]   frames_in_use,
    input  logic [PAGE_BITS-1:0]   pages [MAX_FRAMES],
    input  logic [SLOT_W-1:0]      ranks [MAX_FRAMES],
    input  logic [CNT_W-1:0]       filled,
    input  logic [LPR_FAULT_W-1:0] faults,
    output logic [PAGE_BITS-1:0]   pages_next [MAX_FRAMES],
    output logic [SLOT_W-1:0]      ranks_next [MAX_FRAMES],
    output logic [CNT_W-1:0]       filled_next,
    output logic [LPR_FAULT_W-1:0] faults_next,
    output lpr_status_t            status,
    output logic [SLOT_W-1:0]      slot,
    output logic [PAGE_BITS-1:0]   evicted_page,
    output logic [LPR_FAULT_W-1:0] fault_count
);

    localparam int CMP_W = (CNT_W > LPR_CFG_W) ? CNT_W : LPR_CFG_W;

    logic [CMP_W-1:0]       limit;
    logic [CMP_W-1:0]       cfg_x;
    logic                   hit;
    logic [SLOT_W-1:0]      hit_idx;
    logic [SLOT_W-1:0]      hit_rank;
    logic                   vic_found;
    logic [SLOT_W-1:0]      vic_idx;
    logic [SLOT_W-1:0]      last_rank;
    logic                   fill;
    logic [SLOT_W-1:0]      old_rank;
    logic [CNT_W-1:0]       count_after;
    logic [LPR_FAULT_W-1:0] faults_inc;

    always_comb
    begin
        cfg_x = CMP_W'(frames_in_use);
        if (cfg_x == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (cfg_x > CMP_W'(MAX_FRAMES))
        begin
            limit = CMP_W'(MAX_FRAMES);
        end
        else
        begin
            limit = cfg_x;
        end
    end

    assign last_rank = SLOT_W'(filled - CNT_W'(1));

    always_comb
    begin
        hit       = 1'b0;
        hit_idx   = '0;
        hit_rank  = '0;
        vic_found = 1'b0;
        vic_idx   = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (!hit && (CNT_W'(i) < filled) && (pages[i] == page))
            begin
                hit      = 1'b1;
                hit_idx  = SLOT_W'(i);
                hit_rank = ranks[i];
            end
            if (!vic_found && (CNT_W'(i) < filled) && (ranks[i] == last_rank))
            begin
                vic_found = 1'b1;
                vic_idx   = SLOT_W'(i);
            end
        end
    end

    assign fill = !hit && (CMP_W'(filled) < limit);

    always_comb
    begin
        if (hit)
        begin
            slot     = hit_idx;
            old_rank = hit_rank;
        end
        else if (fill)
        begin
            slot     = SLOT_W'(filled);
            old_rank = '0;
        end
        else
        begin
            slot     = vic_idx;
            old_rank = last_rank;
        end
    end

    assign count_after = fill ? (filled + CNT_W'(1)) : filled;
    assign faults_inc  = (!hit && (faults != '1)) ? (faults + LPR_FAULT_W'(1)) : faults;

    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            pages_next[i] = pages[i];
            if (final_access)
            begin
                ranks_next[i] = '0;
            end
            else if (SLOT_W'(i) == slot)
            begin
                ranks_next[i] = '0;
            end
            else if ((CNT_W'(i) < count_after) && (fill || (ranks[i] < old_rank)))
            begin
                ranks_next[i] = ranks[i] + SLOT_W'(1);
            end
            else
            begin
                ranks_next[i] = ranks[i];
            end
        end
        if (!hit)
        begin
            pages_next[slot] = page;
        end
    end

    assign filled_next          = final_access ? '0 : count_after;
    assign faults_next          = final_access ? '0 : faults_inc;
    assign fault_count          = faults_inc;
    assign status.hit           = hit;
    assign status.evicted_valid = !hit && !fill;
    assign evicted_page         = (!hit && !fill) ? pages[vic_idx] : '0;

endmodule

FILE: src/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page frame table with hit, slot, eviction and fault count per reference.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one page reference per request (page, final_access).
//   rsp  : one result per request (hit, slot, evicted_valid, evicted_page,
//          fault_count), in request order.
//   cfg  : frames_in_use write channel, always ready; write only while idle.
// A request is held in the input register, then its result in the
// result register; one request is taken every cycle while the receiver
// does not stall. The rate is set by the combinational compare of all
// frames and rank update between the input and result registers.
// A request marked final_access clears the table, ranks and fault count
// once its result is computed.
// Reset empties the table and sets frames_in_use to 8.
// When the receiver stalls, the result register holds, the input register
// fills, and req.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module lru_page_replacement
    import lpr_pkg::*;
#(
    parameter int MAX_FRAMES = LPR_MAX_FRAMES,
    parameter int PAGE_BITS  = LPR_PAGE_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    lpr_req_if.sink   req,
    lpr_rsp_if.source rsp,
    lpr_cfg_if.sink   cfg
);

    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

    logic                   in_valid_reg;
    logic [PAGE_BITS-1:0]   in_page_reg;
    logic                   in_final_reg;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic                   out_ev_valid_reg;
    logic [PAGE_BITS-1:0]   out_ev_page_reg;
    logic [LPR_FAULT_W-1:0] out_faults_reg;
    logic [LPR_CFG_W-1:0]   frames_reg;
    logic [PAGE_BITS-1:0]   pages_reg  [MAX_FRAMES];
    logic [PAGE_BITS-1:0]   pages_next [MAX_FRAMES];
    logic [SLOT_W-1:0]      ranks_reg  [MAX_FRAMES];
    logic [SLOT_W-1:0]      ranks_next [MAX_FRAMES];
    logic [CNT_W-1:0]       filled_reg;
    logic [CNT_W-1:0]       filled_next;
    logic [LPR_FAULT_W-1:0] faults_reg;
    logic [LPR_FAULT_W-1:0] faults_next;
    lpr_status_t            status;
    logic [SLOT_W-1:0]      slot;
    logic [PAGE_BITS-1:0]   evicted_page;
    logic [LPR_FAULT_W-1:0] fault_count;
    logic                   advance;
    logic                   take;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    lpr_policy #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .SLOT_W     (SLOT_W),
        .CNT_W      (CNT_W)
    ) u_policy (
        .page          (in_page_reg),
        .final_access  (in_final_reg),
        .frames_in_use (frames_reg),
        .pages         (pages_reg),
        .ranks         (ranks_reg),
        .filled        (filled_reg),
        .faults        (faults_reg),
        .pages_next    (pages_next),
        .ranks_next    (ranks_next),
        .filled_next   (filled_next),
        .faults_next   (faults_next),
        .status        (status),
        .slot          (slot),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            frames_reg    <= LPR_FRAMES_RESET;
            filled_reg    <= '0;
            faults_reg    <= '0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                ranks_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                frames_reg <= cfg.data;
            end
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                filled_reg    <= filled_next;
                faults_reg    <= faults_next;
                ranks_reg     <= ranks_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold payload; advance on handshake
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_page_reg  <= req.page;
            in_final_reg <= req.final_access;
        end
        if (advance)
        begin
            pages_reg        <= pages_next;
            out_hit_reg      <= status.hit;
            out_slot_reg     <= slot;
            out_ev_valid_reg <= status.evicted_valid;
            out_ev_page_reg  <= evicted_page;
            out_faults_reg   <= fault_count;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.slot          = out_slot_reg;
    assign rsp.evicted_valid = out_ev_valid_reg;
    assign rsp.evicted_page  = out_ev_page_reg;
    assign rsp.fault_count   = out_faults_reg;

endmodule
